// ===== sv/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types, codes and helpers for the stride readahead predictor: the
// table entry layout, command and model codes, and saturating arithmetic.
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int NUM_STREAMS_DEF = 512;

    // Fixed field widths
    localparam int PAGE_W   = 32;
    localparam int CONF_W   = 7;
    localparam int WIN_W    = 16;
    localparam int ID_W     = 9;
    localparam int CFG_IX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_CONF_CAP = 8'd0;
    localparam logic [CFG_IX_W-1:0] CFG_SEQ_WIN  = 8'd1;
    localparam logic [CFG_IX_W-1:0] CFG_STR_WIN  = 8'd2;
    localparam logic [CFG_IX_W-1:0] CFG_SCAT_WIN = 8'd3;

    // Reset values and fixed figures of the prediction rules
    localparam logic [CONF_W-1:0] CONF_MAX       = 7'd100;
    localparam logic [CONF_W-1:0] CAP_RESET      = 7'd95;
    localparam logic [WIN_W-1:0]  SEQ_WIN_RESET  = 16'd32;
    localparam logic [WIN_W-1:0]  STR_WIN_RESET  = 16'd16;
    localparam logic [WIN_W-1:0]  SCAT_WIN_RESET = 16'd4;
    localparam logic [CONF_W-1:0] CONF_SEQ_STEP  = 7'd15;
    localparam logic [CONF_W-1:0] CONF_STR_STEP  = 7'd20;
    localparam logic [CONF_W-1:0] CONF_STR_FIRST = 7'd20;
    localparam logic [CONF_W-1:0] CONF_SCAT_DROP = 7'd5;
    localparam logic [CONF_W-1:0] CONF_HIT_STEP  = 7'd5;
    localparam logic [CONF_W-1:0] CONF_MISS_DROP = 7'd10;
    localparam logic [CONF_W-1:0] CONF_RANDOM    = 7'd10;
    localparam logic [CONF_W-1:0] CONF_SAME      = 7'd50;
    localparam logic [CONF_W-1:0] CONF_UNKNOWN   = 7'd20;
    localparam logic [WIN_W-1:0]  WIN_SAME       = 16'd1;
    localparam logic [WIN_W-1:0]  WIN_UNKNOWN    = 16'd8;
    localparam logic [PAGE_W-1:0] MADE_MIN       = 32'd5;
    localparam logic [PAGE_W-1:0] CNT_MAX        = '1;

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_HIT    = 2'd1,
        CMD_MISS   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        MODEL_UNKNOWN = 3'd0,
        MODEL_SEQ     = 3'd1,
        MODEL_STRIDED = 3'd2,
        MODEL_RANDOM  = 3'd3,
        MODEL_SAME    = 3'd4
    } t_model;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_WRITE
    } t_state;

    // One table entry, as held in the entry memory
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] last_page;
        logic [PAGE_W-1:0] previous_page;
        logic [1:0]        history_count;
        t_model            pattern_model;
        logic [PAGE_W-1:0] stride_value;
        logic [CONF_W-1:0] pattern_certainty;
        logic [1:0]        sequential_run;
        logic [1:0]        scattered_run;
        logic [PAGE_W-1:0] predictions_made;
        logic [PAGE_W-1:0] predictions_hit;
    } t_entry;

    // Control outcome of one evaluated transaction
    typedef struct packed {
        logic wr;     // write the updated entry back
        logic found;  // entry was valid or has been created
        logic pred;   // report a prediction from the updated entry
    } t_eval_ctl;

    function automatic logic [CONF_W-1:0] conf_add(input logic [CONF_W-1:0] c,
                                                   input logic [CONF_W-1:0] d);
        logic [CONF_W:0] s;
        s = {1'b0, c} + {1'b0, d};
        return (s > {1'b0, CONF_MAX}) ? CONF_MAX : s[CONF_W-1:0];
    endfunction

    function automatic logic [CONF_W-1:0] conf_sub(input logic [CONF_W-1:0] c,
                                                   input logic [CONF_W-1:0] d);
        return (c >= d) ? (c - d) : '0;
    endfunction

    function automatic logic [1:0] run_inc(input logic [1:0] r);
        return (r == 2'd3) ? 2'd3 : (r + 2'd1);
    endfunction

endpackage

// ===== sv/srp_table.sv =====
// ----------------------------------------------------------------------------
// srp_table
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srp_table #(
    parameter int NUM_STREAMS = srp_pkg::NUM_STREAMS_DEF,
    parameter int IDX_W       = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output srp_pkg::t_entry      o_rd_data,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  srp_pkg::t_entry      i_wr_data
);
    import srp_pkg::*;

    t_entry r_mem [NUM_STREAMS];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/srp_eval.sv =====
// ----------------------------------------------------------------------------
// srp_eval
// Entry update: classifies a recorded page against the entry history and
// applies confirm hit, confirm miss and clear to the entry read from memory.
// ----------------------------------------------------------------------------
module srp_eval (
    input  srp_pkg::t_entry               i_entry,
    input  srp_pkg::t_cmd                 i_cmd,
    input  logic [srp_pkg::PAGE_W-1:0]    i_page_offset,
    output srp_pkg::t_entry               o_entry,
    output srp_pkg::t_eval_ctl            o_ctl
);
    import srp_pkg::*;

    t_entry            w_base;
    t_entry            w_rec;
    logic [PAGE_W-1:0] w_last_inc;
    logic [PAGE_W-1:0] w_step_prev;
    logic [PAGE_W-1:0] w_step_new;
    logic [1:0]        w_seq_run;
    logic [1:0]        w_scat_run;
    logic [PAGE_W+6:0] w_hit_x100;
    logic [PAGE_W+6:0] w_made_x30;
    logic              w_demote;

    // Start a fresh entry when recording on an invalid one
    always_comb begin
        w_base = i_entry;
        if (!i_entry.valid) begin
            w_base       = '0;
            w_base.valid = 1'b1;
        end
    end

    assign w_last_inc  = w_base.last_page + PAGE_W'(1);
    assign w_step_prev = w_base.last_page - w_base.previous_page;
    assign w_step_new  = i_page_offset - w_base.last_page;
    assign w_seq_run   = run_inc(w_base.sequential_run);
    assign w_scat_run  = run_inc(w_base.scattered_run);

    // Hit ratio under 30 percent: hit*100 < made*30, by shifts, adds and a subtraction
    assign w_hit_x100 = ((PAGE_W+7)'(i_entry.predictions_hit) << 6)
                      + ((PAGE_W+7)'(i_entry.predictions_hit) << 5)
                      + ((PAGE_W+7)'(i_entry.predictions_hit) << 2);
    assign w_made_x30 = ((PAGE_W+7)'(i_entry.predictions_made) << 5)
                      - ((PAGE_W+7)'(i_entry.predictions_made) << 1);
    assign w_demote   = (i_entry.predictions_made > MADE_MIN) && (w_hit_x100 < w_made_x30);

    // Record: classify the new page and advance the history unless the page repeats
    always_comb begin
        w_rec = w_base;
        if (w_base.history_count == 2'd0) begin
            w_rec.last_page     = i_page_offset;
            w_rec.history_count = 2'd1;
            w_rec.pattern_model = MODEL_UNKNOWN;
        end else if (i_page_offset == w_base.last_page) begin
            w_rec.pattern_model = MODEL_SAME;
        end else begin
            if (i_page_offset == w_last_inc) begin
                w_rec.sequential_run = w_seq_run;
                w_rec.scattered_run  = 2'd0;
                if (w_seq_run >= 2'd2) begin
                    w_rec.pattern_model     = MODEL_SEQ;
                    w_rec.stride_value      = PAGE_W'(1);
                    w_rec.pattern_certainty = conf_add(w_base.pattern_certainty,
                                                       CONF_SEQ_STEP);
                end
            end else if (w_base.history_count == 2'd3) begin
                if ((w_step_prev == w_step_new) && (w_step_prev != '0)) begin
                    w_rec.stride_value      = w_step_prev;
                    w_rec.pattern_certainty = conf_add(w_base.pattern_certainty,
                                                       CONF_STR_STEP);
                    w_rec.pattern_model     = MODEL_STRIDED;
                    w_rec.sequential_run    = 2'd0;
                    w_rec.scattered_run     = 2'd0;
                end else begin
                    w_rec.scattered_run     = w_scat_run;
                    w_rec.sequential_run    = 2'd0;
                    w_rec.pattern_certainty = conf_sub(w_base.pattern_certainty,
                                                       CONF_SCAT_DROP);
                    w_rec.pattern_model     = (w_scat_run == 2'd3) ? MODEL_RANDOM
                                                                   : MODEL_UNKNOWN;
                end
            end else begin
                w_rec.stride_value      = w_step_new;
                w_rec.pattern_certainty = CONF_STR_FIRST;
                w_rec.pattern_model     = MODEL_STRIDED;
                w_rec.scattered_run     = 2'd0;
            end
            w_rec.previous_page = w_base.last_page;
            w_rec.last_page     = i_page_offset;
            w_rec.history_count = run_inc(w_base.history_count);
        end
        if (w_base.predictions_made != CNT_MAX) begin
            w_rec.predictions_made = w_base.predictions_made + PAGE_W'(1);
        end
    end

    // Select the update for the command
    always_comb begin
        o_entry = i_entry;
        o_ctl   = '0;
        case (i_cmd)
            CMD_RECORD: begin
                o_entry = w_rec;
                o_ctl   = '{wr: 1'b1, found: 1'b1, pred: 1'b1};
            end
            CMD_HIT: begin
                if (i_entry.predictions_hit != CNT_MAX) begin
                    o_entry.predictions_hit = i_entry.predictions_hit + PAGE_W'(1);
                end
                o_entry.pattern_certainty = conf_add(i_entry.pattern_certainty,
                                                     CONF_HIT_STEP);
                o_ctl = '{wr: i_entry.valid, found: i_entry.valid, pred: i_entry.valid};
            end
            CMD_MISS: begin
                o_entry.pattern_certainty = conf_sub(i_entry.pattern_certainty,
                                                     CONF_MISS_DROP);
                if (w_demote) begin
                    o_entry.pattern_model = MODEL_RANDOM;
                end
                o_ctl = '{wr: i_entry.valid, found: i_entry.valid, pred: i_entry.valid};
            end
            CMD_CLEAR: begin
                o_entry.valid = 1'b0;
                o_ctl = '{wr: i_entry.valid, found: i_entry.valid, pred: 1'b0};
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

// ===== sv/stride_readahead_predictor_top.sv =====
// ----------------------------------------------------------------------------
// stride_readahead_predictor_top
// Per-stream access pattern table for readahead: record, confirm hit,
// confirm miss and clear commands, one prediction result per command.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Contents
//  s_axis    in         s_axis_tvalid/tready    tuser: cmd; tdata: stream_id,
//                                               page_offset
//  m_axis    out        m_axis_tvalid/tready    tdata: entry_found, model,
//                                               predicted_page, confidence,
//                                               window_pages
//  cfg       in         i_cfg_valid/o_cfg_ready index and write data
//
//  Each command passes through accept with memory read, evaluate, then write
//  back with the result loaded into the output register; the single entry
//  memory's read-modify-write sets this order.
//  After reset a clearing pass writes every entry invalid in turn;
//  no command is taken during it, configuration writes are.
//  A stalled result holds the block in its write-back cycle; the next command
//  is accepted while an earlier result waits in the output register.
// ----------------------------------------------------------------------------
module stride_readahead_predictor_top #(
    parameter int NUM_STREAMS = srp_pkg::NUM_STREAMS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [47:0]                    s_axis_tdata,  // stream_id[8:0], page_offset[40:9]
    input  logic [1:0]                     s_axis_tuser,  // cmd[1:0]
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [63:0]                    m_axis_tdata,  // entry_found[0], model[3:1],
                                                          // predicted_page[35:4],
                                                          // confidence[42:36],
                                                          // window_pages[58:43]
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [srp_pkg::CFG_IX_W-1:0]   i_cfg_index,
    input  logic [srp_pkg::WIN_W-1:0]      i_cfg_data
);
    import srp_pkg::*;

    localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_clr_addr;
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_addr;
    logic [PAGE_W-1:0]  r_off;
    logic               r_in_range;
    t_entry             r_new;
    t_eval_ctl          r_ctl;

    logic [CONF_W-1:0]  r_cap;
    logic [WIN_W-1:0]   r_seq_win;
    logic [WIN_W-1:0]   r_str_win;
    logic [WIN_W-1:0]   r_scat_win;

    logic               r_out_valid;
    logic               r_out_found;
    t_model             r_out_model;
    logic [PAGE_W-1:0]  r_out_page;
    logic [CONF_W-1:0]  r_out_conf;
    logic [WIN_W-1:0]   r_out_win;

    logic               w_accept;
    logic               w_out_free;
    logic               w_ready;
    logic               w_rd_en;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    t_entry             w_wr_data;
    logic               w_load_out;
    logic               w_clr_last;
    t_entry             w_rd_data;
    t_entry             w_eval_entry;
    t_eval_ctl          w_eval_ctl;
    logic               w_cfg_wr;
    logic [CONF_W-1:0]  w_cap_in;

    t_model             w_p_model;
    logic [PAGE_W-1:0]  w_p_page;
    logic [CONF_W-1:0]  w_p_conf;
    logic [CONF_W-1:0]  w_p_capped;
    logic [WIN_W-1:0]   w_p_win;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_clr_last = (r_clr_addr == IDX_W'(NUM_STREAMS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (w_clr_last)  n_state = S_IDLE;
            S_IDLE:  if (w_accept)    n_state = S_EVAL;
            S_EVAL:                   n_state = S_WRITE;
            S_WRITE: if (w_out_free)  n_state = S_IDLE;
            default:                  n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_ready    = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_addr;
        w_wr_data  = r_new;
        w_load_out = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_addr;
                w_wr_data = '0;
            end
            S_IDLE: begin
                w_ready = 1'b1;
            end
            S_WRITE: begin
                w_load_out = w_out_free;
                w_wr_en    = w_out_free && r_ctl.wr;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = w_ready;
    assign w_rd_en       = w_accept && (32'(s_axis_tdata[ID_W-1:0]) < 32'(NUM_STREAMS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
        end
    end

    // Capture the accepted command
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= t_cmd'(s_axis_tuser);
            r_addr     <= IDX_W'(s_axis_tdata[ID_W-1:0]);
            r_off      <= s_axis_tdata[ID_W+PAGE_W-1:ID_W];
            r_in_range <= w_rd_en;
        end
    end

    srp_table #(
        .NUM_STREAMS (NUM_STREAMS),
        .IDX_W       (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (IDX_W'(s_axis_tdata[ID_W-1:0])),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    srp_eval u_eval (
        .i_entry       (w_rd_data),
        .i_cmd         (r_cmd),
        .i_page_offset (r_off),
        .o_entry       (w_eval_entry),
        .o_ctl         (w_eval_ctl)
    );

    // Hold the updated entry; an out-of-range stream changes nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (r_state == S_EVAL) begin
            r_ctl <= r_in_range ? w_eval_ctl : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            r_new <= w_eval_entry;
        end
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_cap_in    = (i_cfg_data[CONF_W-1:0] > CONF_MAX) ? CONF_MAX
                                                             : i_cfg_data[CONF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RESET;
            r_seq_win  <= SEQ_WIN_RESET;
            r_str_win  <= STR_WIN_RESET;
            r_scat_win <= SCAT_WIN_RESET;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_CONF_CAP: r_cap      <= w_cap_in;
                CFG_SEQ_WIN:  r_seq_win  <= i_cfg_data;
                CFG_STR_WIN:  r_str_win  <= i_cfg_data;
                CFG_SCAT_WIN: r_scat_win <= i_cfg_data;
                default:      r_cap      <= r_cap;
            endcase
        end
    end

    // Prediction from the updated entry
    assign w_p_capped = (r_new.pattern_certainty < r_cap) ? r_new.pattern_certainty : r_cap;

    always_comb begin
        w_p_model = r_new.pattern_model;
        case (r_new.pattern_model)
            MODEL_SEQ: begin
                w_p_page = r_new.last_page + PAGE_W'(1);
                w_p_conf = w_p_capped;
                w_p_win  = r_seq_win;
            end
            MODEL_STRIDED: begin
                w_p_page = r_new.last_page + r_new.stride_value;
                w_p_conf = w_p_capped;
                w_p_win  = r_str_win;
            end
            MODEL_RANDOM: begin
                w_p_page = '0;
                w_p_conf = CONF_RANDOM;
                w_p_win  = r_scat_win;
            end
            MODEL_SAME: begin
                w_p_page = r_new.last_page;
                w_p_conf = CONF_SAME;
                w_p_win  = WIN_SAME;
            end
            default: begin
                w_p_model = MODEL_UNKNOWN;
                w_p_page  = r_new.last_page + PAGE_W'(1);
                w_p_conf  = CONF_UNKNOWN;
                w_p_win   = WIN_UNKNOWN;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_found <= r_ctl.found;
            if (r_ctl.pred) begin
                r_out_model <= w_p_model;
                r_out_page  <= w_p_page;
                r_out_conf  <= w_p_conf;
                r_out_win   <= w_p_win;
            end else begin
                r_out_model <= MODEL_UNKNOWN;
                r_out_page  <= '0;
                r_out_conf  <= '0;
                r_out_win   <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_win, r_out_conf, r_out_page, r_out_model, r_out_found};

endmodule

// ===== sv/srp_checker.sv =====
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks on the stride readahead predictor, bound to the top level.
// ----------------------------------------------------------------------------
module srp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    import srp_pkg::*;

    // Drop any pending result on reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // One command at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while one is in progress");

    // A not-found result carries nothing but zeros
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[63:1] == '0)
        else $error("not-found result with non-zero fields");

    // Random model predicts no page at fixed confidence
    a_random_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3:1] == MODEL_RANDOM)
        |-> (m_axis_tdata[35:4] == '0) && (m_axis_tdata[42:36] == CONF_RANDOM))
        else $error("random result with page or wrong confidence");

endmodule

bind stride_readahead_predictor_top srp_checker u_srp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
